### rtl/aes256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_pkg
// Shared constants, types and byte functions for the AES-256 encrypt pipeline.
// ----------------------------------------------------------------------------
package aes256_pkg;

    localparam int NUM_ROUNDS = 14;
    localparam int NUM_KEYREG = 4;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0 = 2'd0,
        REG_KEY_1 = 2'd1,
        REG_KEY_2 = 2'd2,
        REG_KEY_3 = 2'd3
    } t_cfg_reg;

    typedef logic [127:0] t_block;
    typedef logic [255:0] t_key;

    // sbox as a constant table
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [8] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

### rtl/aes256_key_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_key_exp
// Expands the 256-bit key into 15 round keys through an 8-row registered
// schedule, one row of eight words per stage, recomputed after a write.
// ----------------------------------------------------------------------------
module aes256_key_exp
    import aes256_pkg::*;
(
    input  wire logic         i_clk,
    input  wire t_key         i_key,
    output t_block            o_rk [NUM_ROUNDS+1]
);

    // schedule rows: each row holds 8 words; row n+1 follows row n through regs
    logic [31:0] r_row [8][8];
    logic [31:0] n_row [8][8];

    always_comb begin
        logic [31:0] t;
        for (int j = 0; j < 8; j++) begin
            n_row[0][j] = i_key[255-32*j -: 32];
        end
        for (int n = 1; n < 8; n++) begin
            for (int j = 0; j < 8; j++) begin
                if (j == 0) begin
                    t = r_row[n-1][7];
                    t = sub_word({t[23:0], t[31:24]}) ^ {RCON[n], 24'h0};
                end else if (j == 4) begin
                    t = sub_word(n_row[n][3]);
                end else begin
                    t = n_row[n][j-1];
                end
                n_row[n][j] = r_row[n-1][j] ^ t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    always_comb begin
        for (int k = 0; k <= NUM_ROUNDS; k++) begin
            o_rk[k] = {r_row[k/2][(k%2)*4], r_row[k/2][(k%2)*4+1],
                       r_row[k/2][(k%2)*4+2], r_row[k/2][(k%2)*4+3]};
        end
    end

endmodule
`default_nettype wire

### rtl/aes256_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_round
// One registered cipher round: sub bytes, shift rows, optional mix columns,
// add round key.
// ----------------------------------------------------------------------------
module aes256_round
    import aes256_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_last,
    input  wire logic   i_vld,
    input  wire t_block i_state,
    input  wire t_block i_rk,
    output logic        o_vld,
    output t_block      o_state
);

    logic   r_vld;
    t_block r_state;
    t_block n_state;

    always_comb begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++) begin
            s[i] = SBOX[i_state[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = s[4*((c+r)%4)+r];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!i_last) begin
                t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) begin
            n_state[127-8*i -: 8] = t[i] ^ i_rk[127-8*i -: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_vld   = r_vld;
    assign o_state = r_state;

endmodule
`default_nettype wire

### rtl/aes256_block_encrypt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_block_encrypt_unit
// AES-256 encryption, fully unrolled into 15 pipeline stages.
//
// channel  handshake                    payload
// item in  i_start / o_busy             i_plain_hi, i_plain_lo
// result   o_done strobe                 o_cipher_hi, o_cipher_lo
// config   i_cfg_valid / o_cfg_ready     i_cfg_idx, i_cfg_data
//
// one item per cycle while busy is low; the stages are the add round key stage and 14 rounds.
// round keys are rebuilt by an 8-stage registered schedule after a key write;
// busy is high in the write cycle and the one after, later rows stay ahead.
// config is ready only while no item is in flight.
// synchronous active-low reset clears valid bits and key registers and
// sets busy, which stays high in the cycle after reset; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module aes256_block_encrypt_unit
    import aes256_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [63:0]          i_plain_hi,
    input  wire logic [63:0]          i_plain_lo,
    output logic                      o_done,
    output logic [63:0]               o_cipher_hi,
    output logic [63:0]               o_cipher_lo,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]          i_cfg_data
);

    logic [63:0] r_key [NUM_KEYREG];
    t_block      rk [NUM_ROUNDS+1];
    logic        r_vld0;
    t_block      r_st0;
    logic        vld [NUM_ROUNDS+1];
    t_block      st  [NUM_ROUNDS+1];
    logic        r_key_wait;
    logic        cfg_fire;
    logic        in_flight;

    // items still needing round keys
    always_comb begin
        in_flight = r_vld0;
        for (int g = 1; g < NUM_ROUNDS; g++) begin
            in_flight = in_flight | vld[g];
        end
    end

    assign o_cfg_ready = !in_flight;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign o_busy      = r_key_wait | cfg_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_wait <= 1'b1;
        end else begin
            r_key_wait <= cfg_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYREG; i++) r_key[i] <= '0;
        end else if (cfg_fire) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_KEY_0: r_key[0] <= i_cfg_data;
                REG_KEY_1: r_key[1] <= i_cfg_data;
                REG_KEY_2: r_key[2] <= i_cfg_data;
                REG_KEY_3: r_key[3] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    aes256_key_exp u_kexp (
        .i_clk (i_clk),
        .i_key ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_rk  (rk)
    );

    // initial add round key stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= i_start & !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st0 <= {i_plain_hi, i_plain_lo} ^ rk[0];
    end

    assign vld[0] = r_vld0;
    assign st[0]  = r_st0;

    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        aes256_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_last  (g == NUM_ROUNDS),
            .i_vld   (vld[g-1]),
            .i_state (st[g-1]),
            .i_rk    (rk[g]),
            .o_vld   (vld[g]),
            .o_state (st[g])
        );
    end

    assign o_done      = vld[NUM_ROUNDS];
    assign o_cipher_hi = st[NUM_ROUNDS][127:64];
    assign o_cipher_lo = st[NUM_ROUNDS][63:0];

`ifndef SYNTH
    a_cfg_blocks_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> o_busy)
        else $error("item accepted with key write");
    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[0] |-> ##14 o_done)
        else $error("result lost in pipeline");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(vld[0], 14))
        else $error("spurious result");
`endif

endmodule
`default_nettype wire
